/* rtl/core/rsiw_pkg.sv */
`timescale 1ns / 1ps

package rsiw_pkg;

	localparam int PRICE_W   = 32;
	localparam int PER_W     = 8;
	localparam int CNT_W     = 9;
	localparam int AVG_W     = 48;
	localparam int RSI_W     = 15;
	localparam int NUM_W     = 64;
	localparam int REM_W     = 49;
	localparam int STEP_W    = 7;

	localparam logic [STEP_W-1:0] DIV_STEPS = 7'd64;
	localparam logic [STEP_W-1:0] RSI_STEPS = 7'd15;

	localparam logic [PER_W-1:0] PERIOD_RESET = 8'd14;
	localparam logic [RSI_W-1:0] RSI_FULL     = 15'd25600;
	localparam logic [RSI_W-1:0] RSI_HALF     = 15'd12800;

	// controller -> datapath
	typedef struct packed {
		logic load;       // take input transfer
		logic eval;       // price change, count, running sums
		logic div_start;  // start average division
		logic div_sel;    // 0: gain, 1: loss
		logic avg_store;  // write divider quotient to selected average
		logic rsi_start;  // start ratio division
		logic rsi_const;  // result is warmup or full-scale value
		logic rsi_store;  // write ratio quotient to result
		logic out_load;   // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic rsi_div;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

/* rtl/core/rsiw_div.sv */
`timescale 1ns / 1ps

// Restoring radix-2 divider, one quotient bit per cycle.
// Partial remainder may be preloaded to skip leading quotient bits.
module rsiw_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rsiw_pkg::REM_W-1:0]     rem_init,
	input  logic [rsiw_pkg::NUM_W-1:0]     num_init,
	input  logic [rsiw_pkg::REM_W-1:0]     divisor,
	input  logic [rsiw_pkg::STEP_W-1:0]    steps,
	output logic                           done,
	output logic [rsiw_pkg::NUM_W-1:0]     quotient
);

	logic                         busy_q;
	logic                         done_q;
	logic [rsiw_pkg::STEP_W-1:0]  cnt_q;
	logic [rsiw_pkg::REM_W-1:0]   rem_q;
	logic [rsiw_pkg::NUM_W-1:0]   num_q;
	logic [rsiw_pkg::REM_W-1:0]   div_q;
	logic [rsiw_pkg::REM_W:0]     trial;
	logic [rsiw_pkg::REM_W:0]     diff;
	logic                         ge;

	assign trial = {rem_q, num_q[rsiw_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num_init;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[rsiw_pkg::REM_W-1:0] : trial[rsiw_pkg::REM_W-1:0];
			num_q <= {num_q[rsiw_pkg::NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

/* rtl/core/rsiw_dp.sv */
`timescale 1ns / 1ps

module rsiw_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rsiw_pkg::cmd_t                  cmd,
	output rsiw_pkg::status_t               status,
	input  logic                            cfg_we,
	input  logic [rsiw_pkg::PER_W-1:0]      cfg_wdata,
	input  logic [rsiw_pkg::PRICE_W-1:0]    in_price,
	input  logic                            in_restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rsiw_pkg::RSI_W-1:0]      out_rsi,
	output logic                            out_rdy
);

	logic [rsiw_pkg::PER_W-1:0]   period_q;
	logic [rsiw_pkg::PRICE_W-1:0] price_q;
	logic [rsiw_pkg::PRICE_W-1:0] prev_q;
	logic [rsiw_pkg::CNT_W-1:0]   cnt_q;
	logic [rsiw_pkg::AVG_W-1:0]   gain_avg_q;
	logic [rsiw_pkg::AVG_W-1:0]   loss_avg_q;
	logic [rsiw_pkg::PRICE_W-1:0] gain_q;
	logic [rsiw_pkg::PRICE_W-1:0] loss_q;
	logic                         smooth_q;
	logic [rsiw_pkg::RSI_W-1:0]   res_q;
	logic                         res_rdy_q;
	logic                         out_valid_q;
	logic [rsiw_pkg::RSI_W-1:0]   out_rsi_q;
	logic                         out_rdy_q;

	logic [rsiw_pkg::PER_W-1:0]   p_eff;
	logic [rsiw_pkg::CNT_W-1:0]   p_ext;
	logic [rsiw_pkg::CNT_W-1:0]   p_plus1;
	logic                         rising;
	logic [rsiw_pkg::PRICE_W-1:0] up;
	logic [rsiw_pkg::PRICE_W-1:0] down;
	logic                         ready;

	// average division operands
	logic [rsiw_pkg::AVG_W-1:0]   avg_sel;
	logic [rsiw_pkg::PRICE_W-1:0] chg_sel;
	logic [rsiw_pkg::AVG_W-1:0]   sum_sel;
	logic [55:0]                  scaled;
	logic [rsiw_pkg::NUM_W-1:0]   num_avg;

	// ratio division operands
	logic [62:0]                  num_rsi;
	logic [rsiw_pkg::REM_W-1:0]   den_rsi;

	logic                         div_start;
	logic [rsiw_pkg::REM_W-1:0]   div_rem;
	logic [rsiw_pkg::NUM_W-1:0]   div_num;
	logic [rsiw_pkg::REM_W-1:0]   div_den;
	logic [rsiw_pkg::STEP_W-1:0]  div_steps;
	logic                         div_done;
	logic [rsiw_pkg::NUM_W-1:0]   div_quo;

	assign p_eff   = (period_q == '0) ? 8'd1 : period_q;
	assign p_ext   = {1'b0, p_eff};
	assign p_plus1 = p_ext + 9'd1;
	assign rising  = price_q > prev_q;
	assign up      = rising ? (price_q - prev_q) : '0;
	assign down    = rising ? '0 : (prev_q - price_q);
	assign ready   = cnt_q > p_ext;

	assign avg_sel = cmd.div_sel ? loss_avg_q : gain_avg_q;
	assign chg_sel = cmd.div_sel ? loss_q : gain_q;
	assign sum_sel = avg_sel + {16'd0, chg_sel};
	assign scaled  = avg_sel * (p_eff - 8'd1);
	assign num_avg = smooth_q ?
		({8'd0, scaled} + {16'd0, chg_sel, 16'd0}) : {sum_sel, 16'd0};

	// 25600 = 2^14 + 2^13 + 2^10
	assign num_rsi = {1'b0, gain_avg_q, 14'd0} + {2'b0, gain_avg_q, 13'd0}
		+ {5'b0, gain_avg_q, 10'd0};
	assign den_rsi = {1'b0, gain_avg_q} + {1'b0, loss_avg_q};

	// ratio quotient is below 2^15: preload the remainder with the top bits
	assign div_start = cmd.div_start | cmd.rsi_start;
	assign div_rem   = cmd.rsi_start ? {1'b0, num_rsi[62:15]} : '0;
	assign div_num   = cmd.rsi_start ? {num_rsi[14:0], 49'd0} : num_avg;
	assign div_den   = cmd.rsi_start ? den_rsi : {41'd0, p_eff};
	assign div_steps = cmd.rsi_start ? rsiw_pkg::RSI_STEPS : rsiw_pkg::DIV_STEPS;

	rsiw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.num_init (div_num),
		.divisor  (div_den),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= rsiw_pkg::PERIOD_RESET;
			prev_q      <= '0;
			cnt_q       <= '0;
			gain_avg_q  <= '0;
			loss_avg_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				period_q <= cfg_wdata;
			if (cmd.load && in_restart) begin
				prev_q     <= '0;
				cnt_q      <= '0;
				gain_avg_q <= '0;
				loss_avg_q <= '0;
			end
			if (cmd.eval) begin
				prev_q <= price_q;
				if (cnt_q == '0) begin
					cnt_q <= 9'd1;
				end else begin
					if (cnt_q < p_ext) begin
						gain_avg_q <= gain_avg_q + {16'd0, up};
						loss_avg_q <= loss_avg_q + {16'd0, down};
					end
					if (cnt_q < p_plus1)
						cnt_q <= cnt_q + 9'd1;
				end
			end
			if (cmd.avg_store) begin
				if (cmd.div_sel)
					loss_avg_q <= div_quo[rsiw_pkg::AVG_W-1:0];
				else
					gain_avg_q <= div_quo[rsiw_pkg::AVG_W-1:0];
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			price_q <= in_price;
		if (cmd.eval) begin
			gain_q   <= up;
			loss_q   <= down;
			smooth_q <= cnt_q > p_ext;
		end
		if (cmd.rsi_const) begin
			res_q     <= ready ? rsiw_pkg::RSI_FULL : rsiw_pkg::RSI_HALF;
			res_rdy_q <= ready;
		end
		if (cmd.rsi_start)
			res_rdy_q <= 1'b1;
		if (cmd.rsi_store)
			res_q <= div_quo[rsiw_pkg::RSI_W-1:0];
		if (cmd.out_load) begin
			out_rsi_q <= res_q;
			out_rdy_q <= res_rdy_q;
		end
	end

	assign status.need_div = (cnt_q != '0) && (cnt_q >= p_ext);
	assign status.rsi_div  = ready && (loss_avg_q != '0);
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_rsi   = out_rsi_q;
	assign out_rdy   = out_rdy_q;

endmodule

/* rtl/core/rsiw_ctrl.sv */
`timescale 1ns / 1ps

module rsiw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsiw_pkg::status_t   status,
	output rsiw_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVAL   = 4'd1;
	localparam logic [3:0] S_GSTART = 4'd2;
	localparam logic [3:0] S_GWAIT  = 4'd3;
	localparam logic [3:0] S_LSTART = 4'd4;
	localparam logic [3:0] S_LWAIT  = 4'd5;
	localparam logic [3:0] S_RSI    = 4'd6;
	localparam logic [3:0] S_RWAIT  = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.need_div ? S_GSTART : S_RSI;
			end
			S_GSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_GWAIT;
			end
			S_GWAIT: begin
				if (status.div_done) begin
					cmd.avg_store = 1'b1;
					state_d       = S_LSTART;
				end
			end
			S_LSTART: begin
				cmd.div_sel   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = S_LWAIT;
			end
			S_LWAIT: begin
				cmd.div_sel = 1'b1;
				if (status.div_done) begin
					cmd.avg_store = 1'b1;
					state_d       = S_RSI;
				end
			end
			S_RSI: begin
				if (status.rsi_div) begin
					cmd.rsi_start = 1'b1;
					state_d       = S_RWAIT;
				end else begin
					cmd.rsi_const = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_RWAIT: begin
				if (status.div_done) begin
					cmd.rsi_store = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* rtl/core/rsi_wilder_streaming_top.sv */
`timescale 1ns / 1ps
// While summing the first changes no division runs; once averages are divided, an item takes two
// 64-step divisions by period and, unless the loss average is 0, a 15-step ratio division, all on
// one shared radix-2 divider. A new item is taken only after the previous one reaches the output
// register; that register lets the next item enter while a result waits. Reset clears the series
// state and sets period to 14.

// Streaming RSI with Wilder smoothing.
// Flow per item: take the price, form the change, then either add it to the running
// sums (warmup, index held at half scale) or divide the gain and loss averages by period,
// then divide 25600 * gain by gain + loss for the index, or give full scale if loss is 0.
module rsi_wilder_streaming_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: period register
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // [7:0] period
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // [31:0] close_price (Q16.16)
	input  logic        s_tuser,     // [0] new_series
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [14:0] rsi_value, [15] zero
	output logic        m_tuser      // [0] ready_res
);

	rsiw_pkg::cmd_t    cmd;
	rsiw_pkg::status_t status;
	logic [14:0]       rsi;

	// sequencer: one item at a time through the shared divider
	rsiw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// state, averages, divider and output register
	rsiw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_price   (s_tdata),
		.in_restart (s_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_rsi    (rsi),
		.out_rdy    (m_tuser)
	);

	// pad the 15-bit index to a whole byte boundary
	assign m_tdata = {1'b0, rsi};

endmodule
